// ===== design/pnfe_pkg.sv =====
`default_nettype none
package pnfe_pkg;
  localparam logic [2:0] OP_SET    = 3'd0;
  localparam logic [2:0] OP_WIN    = 3'd1;
  localparam logic [2:0] OP_WOUT   = 3'd2;
  localparam logic [2:0] OP_FIRE   = 3'd3;
  localparam logic [2:0] OP_STEP   = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;
  localparam logic [2:0] OP_SPARE0 = 3'd6;
  localparam logic [2:0] OP_SPARE1 = 3'd7;
  localparam logic [15:0] SEED_RESET = 16'd44257;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;
  localparam int unsigned CFG_SEED_IDX = 0;
  localparam int unsigned PLACE_COUNT      = 16;
  localparam int unsigned TRANSITION_COUNT = 16;
  localparam int unsigned WEIGHT_BITS      = 8;
  localparam int unsigned TOKEN_BITS       = 16;
endpackage
`default_nettype wire

// ===== design/pnfe_ram.sv =====
`default_nettype none
module pnfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/petri_net_firing_engine_top.sv =====
// petri net firing engine: one item at a time, busy from the accepting edge to the strobe
// set, arc write, read and spare ops: through the read and done states to the strobe
// fire: scan, pick, subtract and add passes; a bad transition index goes straight to done
// step: a scan of every transition, pick, then the subtract and add passes
// the passes are skipped when nothing fires; the receiver cannot stall, the strobe lasts one cycle
// sync reset clears the marking; a clearing pass then zeroes the arc memories
`default_nettype none
module petri_net_firing_engine_top import pnfe_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [2:0]  in_op,
  input  wire  [3:0]  in_place,
  input  wire  [3:0]  in_transition,
  input  wire  [15:0] in_token_value,
  input  wire  [7:0]  in_weight,
  output logic        out_strobe,
  output logic        out_status,
  output logic        out_fired,
  output logic [3:0]  out_fired_transition,
  output logic [4:0]  out_enabled_count,
  output logic [15:0] out_read_tokens,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [1:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned PW = (PLACE_COUNT > 1) ? $clog2(PLACE_COUNT) : 1;
  localparam int unsigned TW = (TRANSITION_COUNT > 1) ? $clog2(TRANSITION_COUNT) : 1;
  localparam int unsigned AW = PW + TW;
  localparam int unsigned AD = PLACE_COUNT * TRANSITION_COUNT;
  localparam int unsigned PC = $clog2(PLACE_COUNT + 1);
  localparam int unsigned TC = $clog2(TRANSITION_COUNT + 1);
  localparam logic [TOKEN_BITS-1:0] TOKEN_MAX = {TOKEN_BITS{1'b1}};

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_SUB  = 4'd3;
  localparam logic [3:0] S_ADD  = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_PICK = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;

  logic [3:0] state_r, state_nxt;
  logic [15:0] seed_r, lfsr_r;
  logic [TOKEN_BITS-1:0] marking_r [PLACE_COUNT];
  logic [2:0] op_r;
  logic [3:0] place_r;
  logic [AW:0] clr_r;
  logic [PC-1:0] pcnt_r;
  logic [TC-1:0] tcnt_r;
  logic [TW-1:0] cur_t_r, start_t_r;
  logic ok_r, stat_r, fired_r;
  logic [4:0] encnt_r;
  logic [TRANSITION_COUNT-1:0] en_r;
  logic pick_found;
  logic [TW-1:0] pick_t;

  logic [WEIGHT_BITS-1:0] wi_rd, wo_rd;
  logic [AW-1:0] raddr, waddr;
  logic wi_we, wo_we;
  logic [WEIGHT_BITS-1:0] wdata;
  logic [PW-1:0] rp_r;
  logic rv_r;

  wire accept = start && !busy;
  wire cfg_wr = psel && penable && pwrite && pready && (paddr == 2'(CFG_SEED_IDX));
  wire place_ok = 32'(in_place) < PLACE_COUNT;
  wire trans_ok = 32'(in_transition) < TRANSITION_COUNT;
  wire [15:0] lfsr_step = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : 16'd0);
  wire [PW-1:0] pidx = pcnt_r[PW-1:0];

  assign busy = (state_r != S_IDLE);
  assign pready = 1'b1;
  assign prdata = {16'd0, seed_r};

  always_comb begin
    raddr = {cur_t_r, pidx};
    wi_we = 1'b0;
    wo_we = 1'b0;
    waddr = {in_transition[TW-1:0], in_place[PW-1:0]};
    wdata = in_weight[WEIGHT_BITS-1:0];
    if (state_r == S_CLR) begin
      wi_we = 1'b1;
      wo_we = 1'b1;
      waddr = clr_r[AW-1:0];
      wdata = '0;
    end else if (accept && place_ok && trans_ok) begin
      wi_we = (in_op == OP_WIN);
      wo_we = (in_op == OP_WOUT);
    end
  end

  pnfe_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(AD)) u_win (
    .clk(clk), .we(wi_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(wi_rd)
  );
  pnfe_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(AD)) u_wout (
    .clk(clk), .we(wo_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(wo_rd)
  );

  // shared unit: compare, subtract or saturating add on the place of the last read
  wire [TOKEN_BITS-1:0] mk = marking_r[rp_r];
  wire [TOKEN_BITS-1:0] wi_ext = TOKEN_BITS'(wi_rd);
  wire [TOKEN_BITS-1:0] wo_ext = TOKEN_BITS'(wo_rd);
  wire [TOKEN_BITS:0] sum = {1'b0, mk} + {1'b0, wo_ext};
  wire wi_gt = ({{(32-WEIGHT_BITS){1'b0}}, wi_rd} > 32'(mk));

  // fire: the given transition if enabled; step: first enabled transition at or after the start index, wrapping
  always_comb begin
    pick_found = 1'b0;
    pick_t = '0;
    if (op_r == OP_FIRE) begin
      pick_found = en_r[cur_t_r];
      pick_t = cur_t_r;
    end else begin
      for (int k = TRANSITION_COUNT - 1; k >= 0; k--) begin
        if (en_r[TW'((32'(start_t_r) + k) % TRANSITION_COUNT)]) begin
          pick_found = 1'b1;
          pick_t = TW'((32'(start_t_r) + k) % TRANSITION_COUNT);
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_r == (AW+1)'(AD - 1)) state_nxt = S_IDLE;
      S_IDLE: if (accept) begin
        case (in_op)
          OP_FIRE: state_nxt = trans_ok ? S_SCAN : S_DONE;
          OP_STEP: state_nxt = S_SCAN;
          default: state_nxt = S_RD;
        endcase
      end
      S_SCAN: if (rv_r && 32'(rp_r) == PLACE_COUNT - 1 &&
                  32'(tcnt_r) >= TRANSITION_COUNT - 1) state_nxt = S_PICK;
      S_PICK: state_nxt = pick_found ? S_SUB : S_RD;
      S_SUB:  if (rv_r && 32'(rp_r) == PLACE_COUNT - 1) state_nxt = S_ADD;
      S_ADD:  if (rv_r && 32'(rp_r) == PLACE_COUNT - 1) state_nxt = S_RD;
      S_RD:   state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      seed_r <= SEED_RESET;
      lfsr_r <= SEED_RESET;
      for (int i = 0; i < PLACE_COUNT; i++) marking_r[i] <= '0;
      out_strobe <= 1'b0;
      rv_r <= 1'b0;
      pcnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_strobe <= 1'b0;
      rv_r <= 1'b0;
      rp_r <= pidx;
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
      if (cfg_wr) begin
        seed_r <= pwdata[15:0];
        lfsr_r <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
      end
      case (state_r)
        S_IDLE: if (accept) begin
          op_r <= in_op;
          place_r <= in_place;
          pcnt_r <= '0;
          stat_r <= 1'b0;
          fired_r <= 1'b0;
          encnt_r <= '0;
          ok_r <= 1'b1;
          en_r <= '0;
          if (in_op == OP_SET && place_ok)
            marking_r[in_place[PW-1:0]] <= in_token_value[TOKEN_BITS-1:0];
          if (in_op == OP_FIRE) begin
            cur_t_r <= in_transition[TW-1:0];
            tcnt_r <= TC'(TRANSITION_COUNT - 1);
            if (!trans_ok) stat_r <= 1'b1;
          end
          if (in_op == OP_STEP) begin
            lfsr_r <= lfsr_step;
            start_t_r <= TW'(32'(lfsr_step) % TRANSITION_COUNT);
            cur_t_r <= '0;
            tcnt_r <= '0;
          end
        end
        S_SCAN, S_SUB, S_ADD: begin
          if (32'(pcnt_r) < PLACE_COUNT) begin
            pcnt_r <= pcnt_r + 1'b1;
            rv_r <= 1'b1;
          end
          if (rv_r) begin
            if (state_r == S_SCAN) begin
              if (wi_gt) ok_r <= 1'b0;
            end else if (state_r == S_SUB) begin
              marking_r[rp_r] <= mk - wi_ext;
            end else begin
              marking_r[rp_r] <= sum[TOKEN_BITS] ? TOKEN_MAX : sum[TOKEN_BITS-1:0];
            end
            if (32'(rp_r) == PLACE_COUNT - 1) begin
              pcnt_r <= '0;
              if (state_r == S_SCAN) begin
                en_r[cur_t_r] <= ok_r && !wi_gt;
                if (32'(tcnt_r) < TRANSITION_COUNT - 1) begin
                  // more transitions to scan
                  tcnt_r <= tcnt_r + 1'b1;
                  cur_t_r <= cur_t_r + 1'b1;
                  ok_r <= 1'b1;
                end
              end
            end
          end
        end
        S_PICK: begin
          if (op_r != OP_FIRE) encnt_r <= 5'($countones(en_r));
          cur_t_r <= pick_t;
          if (pick_found) begin
            fired_r <= 1'b1;
            pcnt_r <= '0;
          end else begin
            stat_r <= 1'b1;
          end
        end
        S_DONE: begin
          out_strobe <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_status <= stat_r;
      out_fired <= fired_r;
      out_fired_transition <= fired_r ? 4'(cur_t_r) : 4'd0;
      out_enabled_count <= encnt_r;
      out_read_tokens <= (32'(place_r) < PLACE_COUNT) ?
                         16'(marking_r[place_r[PW-1:0]]) : 16'd0;
    end
  end

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("strobe held");
  a_busy_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("strobe while busy");
  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_fired |-> !out_status) else $error("fired with error");
endmodule
`default_nettype wire

// ===== sim/tb_petri_net_firing_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_petri_net_firing_engine_top import pnfe_pkg::*; ();

  typedef struct packed {
    logic        status;
    logic        fired;
    logic [3:0]  fired_transition;
    logic [4:0]  enabled_count;
    logic [15:0] read_tokens;
  } net_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_op = '0;
  logic [3:0] in_place = '0;
  logic [3:0] in_transition = '0;
  logic [15:0] in_token_value = '0;
  logic [7:0] in_weight = '0;
  logic out_strobe;
  logic out_status;
  logic out_fired;
  logic [3:0] out_fired_transition;
  logic [4:0] out_enabled_count;
  logic [15:0] out_read_tokens;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  petri_net_firing_engine_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_place(in_place), .in_transition(in_transition),
    .in_token_value(in_token_value), .in_weight(in_weight),
    .out_strobe(out_strobe), .out_status(out_status), .out_fired(out_fired),
    .out_fired_transition(out_fired_transition),
    .out_enabled_count(out_enabled_count), .out_read_tokens(out_read_tokens),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  logic [15:0] tokens [16];
  logic [7:0] in_arc [16][16];
  logic [7:0] out_arc [16][16];
  logic [15:0] lfsr;
  net_result_t pending_results [$];
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int fires_seen = 0;

  function automatic bit transition_enabled(int t);
    for (int p = 0; p < 16; p++)
      if (in_arc[t][p] > tokens[p]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void fire_transition(int t);
    logic [16:0] sum;
    for (int p = 0; p < 16; p++) tokens[p] = tokens[p] - in_arc[t][p];
    for (int p = 0; p < 16; p++) begin
      sum = tokens[p] + out_arc[t][p];
      tokens[p] = sum[16] ? 16'hFFFF : sum[15:0];
    end
  endfunction

  function automatic net_result_t predict_net(logic [2:0] op, logic [3:0] pl,
                                              logic [3:0] tr, logic [15:0] tv,
                                              logic [7:0] w);
    net_result_t r;
    int first;
    bit found;
    r = '0;
    found = 1'b0;
    case (op)
      OP_SET: tokens[pl] = tv;
      OP_WIN: in_arc[tr][pl] = w;
      OP_WOUT: out_arc[tr][pl] = w;
      OP_FIRE: begin
        if (transition_enabled(tr)) begin
          fire_transition(tr);
          r.fired = 1'b1;
          r.fired_transition = tr;
        end else begin
          r.status = 1'b1;
        end
      end
      OP_STEP: begin
        lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
        first = lfsr % 16;
        for (int t = 0; t < 16; t++)
          if (transition_enabled(t)) r.enabled_count++;
        for (int k = 0; k < 16; k++)
          if (!found && transition_enabled((first + k) % 16)) begin
            found = 1'b1;
            r.fired_transition = 4'((first + k) % 16);
          end
        if (found) begin
          fire_transition(r.fired_transition);
          r.fired = 1'b1;
        end else begin
          r.status = 1'b1;
        end
      end
      default: ;
    endcase
    r.read_tokens = tokens[pl];
    return r;
  endfunction

  always @(posedge clk) begin
    net_result_t got, want;
    if (rst_n && out_strobe) begin
      got = '{out_status, out_fired, out_fired_transition, out_enabled_count,
              out_read_tokens};
      results_seen++;
      if (out_fired) fires_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected st=%0d f=%0d t=%0d en=%0d rd=%0d,",
                      " got st=%0d f=%0d t=%0d en=%0d rd=%0d"},
                     want.status, want.fired, want.fired_transition,
                     want.enabled_count, want.read_tokens, got.status, got.fired,
                     got.fired_transition, got.enabled_count, got.read_tokens);
        end
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(logic [2:0] op, logic [3:0] pl, logic [3:0] tr,
                           logic [15:0] tv, logic [7:0] w);
    net_result_t want;
    start <= 1'b1;
    in_op <= op;
    in_place <= pl;
    in_transition <= tr;
    in_token_value <= tv;
    in_weight <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = predict_net(op, pl, tr, tv, w);
    pending_results = {pending_results, want};
    items_sent++;
    idle_gap();
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  task automatic write_seed(logic [15:0] seed);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 2'(CFG_SEED_IDX);
    pwdata <= {16'h0, seed};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    lfsr = (seed == 16'h0) ? 16'h1 : seed;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (prdata !== {16'h0, seed}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("seed readback: expected %h, got %h", {16'h0, seed}, prdata);
    end
  endtask

  task automatic test_directed();
    send_item(OP_STEP, 4'd0, 4'd0, 16'h0, 8'h0);
    send_item(OP_SET, 4'd15, 4'd0, 16'hFFFF, 8'h0);
    send_item(OP_SET, 4'd0, 4'd0, 16'd5, 8'h0);
    send_item(OP_WIN, 4'd0, 4'd15, 16'h0, 8'hFF);
    send_item(OP_FIRE, 4'd0, 4'd15, 16'h0, 8'h0);
    send_item(OP_WIN, 4'd0, 4'd15, 16'h0, 8'd3);
    send_item(OP_WOUT, 4'd15, 4'd15, 16'h0, 8'hFF);
    send_item(OP_FIRE, 4'd15, 4'd15, 16'h0, 8'h0);
    send_item(OP_WIN, 4'd0, 4'd0, 16'h0, 8'd2);
    send_item(OP_WOUT, 4'd0, 4'd0, 16'h0, 8'd7);
    send_item(OP_FIRE, 4'd0, 4'd0, 16'h0, 8'h0);
    for (int t = 0; t < 16; t++) send_item(OP_WIN, 4'd1, 4'(t), 16'h0, 8'd1);
    send_item(OP_STEP, 4'd1, 4'd0, 16'h0, 8'h0);
    send_item(OP_SET, 4'd1, 4'd0, 16'hAAAA, 8'h0);
    send_item(OP_STEP, 4'd1, 4'd0, 16'h0, 8'h0);
    send_item(OP_READ, 4'd1, 4'd0, 16'h0, 8'h0);
    send_item(OP_SPARE0, 4'd0, 4'd9, 16'h5555, 8'h55);
    send_item(OP_SPARE1, 4'd15, 4'd6, 16'h0, 8'hAA);
  endtask

  task automatic test_random(int count, logic [15:0] seed);
    logic [2:0] op;
    int pick;
    write_seed(seed);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) op = OP_SET;
      else if (pick < 35) op = OP_WIN;
      else if (pick < 50) op = OP_WOUT;
      else if (pick < 65) op = OP_FIRE;
      else if (pick < 88) op = OP_STEP;
      else if (pick < 96) op = OP_READ;
      else op = ($urandom_range(0, 1) == 0) ? OP_SPARE0 : OP_SPARE1;
      send_item(op, 4'($urandom), 4'($urandom),
                ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
                ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)));
    end
  endtask

  initial begin
    for (int p = 0; p < 16; p++) begin
      tokens[p] = '0;
      for (int t = 0; t < 16; t++) begin
        in_arc[t][p] = '0;
        out_arc[t][p] = '0;
      end
    end
    lfsr = SEED_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (300) @(posedge clk);
    test_directed();
    test_random(500, 16'd1);
    test_random(500, 16'hFFFF);
    test_random(500, 16'h0);
    test_random(500, 16'($urandom_range(1, 65535)));
    drain();
    $display("%0d items sent, %0d results checked, %0d fires, over four seed settings",
             items_sent, results_seen, fires_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
